>>> hw/rtl/spf_pkg.sv
// Shared constants, command and status types for the smallest-prime-factor factorizer.
// Used by spf_divider, spf_datapath, spf_ctrl and the top level; no dependencies.
package spf_pkg;

   // Largest number the table covers
   localparam int MAX_NUMBER = 65535;
   localparam int TABLE_TOP  = (MAX_NUMBER < 65535) ? MAX_NUMBER : 65535;

   // Field and table widths
   localparam int NUM_W  = 16;
   localparam int ADDR_W = $clog2(TABLE_TOP + 1);
   localparam int J_W    = ADDR_W + 1;

   // Floor of the square root, evaluated at elaboration only
   function automatic int isqrt_floor(input int v);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   // Sieve runs its strike-out loop for every p from SIEVE_TOP down to 2
   localparam int SIEVE_TOP = isqrt_floor(TABLE_TOP);
   localparam int P_W       = $clog2(SIEVE_TOP + 1);

   // At most this many results per input word
   localparam int RESULT_LIMIT = 16;
   localparam int CNT_W        = $clog2(RESULT_LIMIT);

   // Restoring divider retires one quotient bit per cycle
   localparam int DIV_STEPS = NUM_W;
   localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

   // Factor codes for the single-result cases
   localparam logic [NUM_W-1:0] FACTOR_ONE   = NUM_W'(1);
   localparam logic [NUM_W-1:0] FACTOR_ERROR = NUM_W'(0);

   // Controller to datapath commands
   typedef struct packed {
      logic init_step;
      logic sieve_load;
      logic sieve_step;
      logic sieve_next;
      logic load_num;
      logic set_special;
      logic read_num;
      logic take_factor;
      logic take_quot;
      logic next_result;
   } spf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic init_last;
      logic j_last;
      logic p_last;
      logic special;
      logic div_busy;
      logic last;
   } spf_status_type;

endpackage

>>> hw/rtl/spf_divider.sv
// Restoring divider: one quotient bit per cycle.
// Depends on spf_pkg.
module spf_divider import spf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [NUM_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);

   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   dvs_ff, dvs_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic [NUM_W:0]     shifted;
   logic [NUM_W:0]     diff;
   logic               fits;

   // Trial subtract of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = ~diff[NUM_W];

   // Load on start, then shift one bit in per step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = DSTEP_W'(DIV_STEPS);
      end else if (step_ff != '0) begin
         rem_in  = fits ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (step_ff != '0);
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/spf_datapath.sv
// Datapath: smallest-prime-factor table memory, sieve counters, remainder and result registers.
// Depends on spf_pkg and spf_divider.
module spf_datapath import spf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  spf_cmd_type      cmd,
   input  logic [NUM_W-1:0] req_number,
   output spf_status_type   status,
   output logic [NUM_W-1:0] rsp_factor,
   output logic             rsp_last_factor,
   output logic             rsp_input_is_prime
);

   logic [NUM_W-1:0]  lft_mem_ff [0:TABLE_TOP];
   logic [NUM_W-1:0]  rd_data_ff;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [P_W-1:0]    p_ff, p_in;
   logic [J_W-1:0]    j_ff, j_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  factor_ff, factor_in;
   logic              last_ff, last_in;
   logic              prime_ff, prime_in;

   logic [J_W-1:0]    j_next;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [NUM_W-1:0]  wr_data;
   logic [NUM_W-1:0]  pick;
   logic              div_busy;
   logic [NUM_W-1:0]  div_quot;

   assign j_next = j_ff + J_W'(p_ff);

   // Table write port: init pass writes each index (0 below 2), sieve writes p over multiples
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = (addr_ff < ADDR_W'(2)) ? '0 : NUM_W'(addr_ff);
      if (cmd.init_step) begin
         wr_en = 1'b1;
      end else if (cmd.sieve_step) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[ADDR_W-1:0];
         wr_data = NUM_W'(p_ff);
      end
   end

   // Table memory with registered read at the current remainder
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lft_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.read_num) begin
         rd_data_ff <= lft_mem_ff[num_ff[ADDR_W-1:0]];
      end
   end

   // Entries below 2 never name a factor: fall back to the remainder
   assign pick = (rd_data_ff < NUM_W'(2)) ? num_ff : rd_data_ff;

   spf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.take_factor),
      .dividend (num_ff),
      .divisor  (pick),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Next-state for counters and result registers
   always_comb begin
      addr_in   = addr_ff;
      p_in      = p_ff;
      j_in      = j_ff;
      num_in    = num_ff;
      cnt_in    = cnt_ff;
      factor_in = factor_ff;
      last_in   = last_ff;
      prime_in  = prime_ff;
      if (cmd.init_step) begin
         addr_in = addr_ff + 1'b1;
      end
      if (cmd.sieve_load) begin
         j_in = J_W'(p_ff) * J_W'(p_ff);
      end
      if (cmd.sieve_step) begin
         j_in = j_next;
      end
      if (cmd.sieve_next) begin
         p_in = p_ff - 1'b1;
      end
      if (cmd.load_num) begin
         num_in   = req_number;
         cnt_in   = '0;
         prime_in = 1'b0;
      end
      if (cmd.set_special) begin
         factor_in = (num_ff < NUM_W'(2)) ? FACTOR_ONE : FACTOR_ERROR;
         last_in   = 1'b1;
      end
      if (cmd.take_factor) begin
         factor_in = pick;
         if (cnt_ff == '0) begin
            prime_in = (rd_data_ff == num_ff);
         end
      end
      if (cmd.take_quot) begin
         num_in  = div_quot;
         last_in = (div_quot <= NUM_W'(1)) || (cnt_ff == CNT_W'(RESULT_LIMIT - 1));
      end
      if (cmd.next_result) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         p_ff    <= P_W'(SIEVE_TOP);
      end else begin
         addr_ff <= addr_in;
         p_ff    <= p_in;
      end
      j_ff      <= j_in;
      num_ff    <= num_in;
      cnt_ff    <= cnt_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
      prime_ff  <= prime_in;
   end

   // Status back to the controller
   assign status.init_last = (addr_ff == ADDR_W'(TABLE_TOP));
   assign status.j_last    = (j_next > J_W'(TABLE_TOP));
   assign status.p_last    = (p_ff == P_W'(2));
   assign status.special   = (num_ff < NUM_W'(2)) || (32'(num_ff) > 32'(TABLE_TOP));
   assign status.div_busy  = div_busy;
   assign status.last      = last_ff;

   assign rsp_factor         = factor_ff;
   assign rsp_last_factor    = last_ff;
   assign rsp_input_is_prime = prime_ff;

   // Never restart the divider mid-division
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.take_factor |-> !div_busy)
      else $error("divider started while busy");

   // Each table factor divides the remainder exactly
   a_exact_division: assert property (@(posedge clock) disable iff (reset)
      cmd.take_quot |-> (32'(div_quot) * 32'(factor_ff) == 32'(num_ff)))
      else $error("factor does not divide remainder");

   // Sieve writes stay inside the table
   a_sieve_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sieve_step |-> (j_ff <= J_W'(TABLE_TOP)))
      else $error("sieve write beyond table");

   // A factor taken from the filled table is at least 2
   a_factor_ge_two: assert property (@(posedge clock) disable iff (reset)
      cmd.take_factor |-> (pick >= NUM_W'(2)))
      else $error("factor below 2");

endmodule

>>> hw/rtl/spf_ctrl.sv
// Controller: init pass, sieve pass, then per-word factor loop and result handshake.
// Depends on spf_pkg.
module spf_ctrl import spf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  spf_status_type status,
   output spf_cmd_type    cmd
);

   localparam logic [2:0] S_INIT    = 3'd0;
   localparam logic [2:0] S_SIEVE_P = 3'd1;
   localparam logic [2:0] S_SIEVE_J = 3'd2;
   localparam logic [2:0] S_IDLE    = 3'd3;
   localparam logic [2:0] S_CHECK   = 3'd4;
   localparam logic [2:0] S_READ    = 3'd5;
   localparam logic [2:0] S_DIV     = 3'd6;
   localparam logic [2:0] S_SEND    = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);

   // Sequence the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) state_in = S_SIEVE_P;
         end
         S_SIEVE_P: begin
            cmd.sieve_load = 1'b1;
            state_in       = S_SIEVE_J;
         end
         S_SIEVE_J: begin
            cmd.sieve_step = 1'b1;
            if (status.j_last) begin
               if (status.p_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.sieve_next = 1'b1;
                  state_in       = S_SIEVE_P;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_num = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.special) begin
               cmd.set_special = 1'b1;
               state_in        = S_SEND;
            end else begin
               cmd.read_num = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            cmd.take_factor = 1'b1;
            state_in        = S_DIV;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               cmd.take_quot = 1'b1;
               state_in      = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_result = 1'b1;
                  cmd.read_num    = 1'b1;
                  state_in        = S_READ;
               end
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/smallest_prime_factor_factorizer.sv
// Top level: prime factorizer over a sieve-filled smallest-prime-factor table.
// Depends on spf_pkg, spf_ctrl and spf_datapath.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   request | req_valid, req_ready, req_number               | in
//   result  | rsp_valid, rsp_ready, rsp_factor,              | out
//           | rsp_last_factor, rsp_input_is_prime            |
//
// After reset the table is filled with each index (0 below 2), then sieved for a
// 65536-entry table; req_ready stays low until both passes are done.
// An input word of 0, 1 or out of range gives a single result; otherwise each factor
// takes a table read and a division in the bit-serial divider, then a send.
// One word is in flight at a time; a stalled result holds the block in its send state.
module smallest_prime_factor_factorizer import spf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [NUM_W-1:0] req_number,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [NUM_W-1:0] rsp_factor,
   output logic             rsp_last_factor,
   output logic             rsp_input_is_prime
);

   spf_cmd_type    cmd;
   spf_status_type status;

   spf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_number         (req_number),
      .status             (status),
      .rsp_factor         (rsp_factor),
      .rsp_last_factor    (rsp_last_factor),
      .rsp_input_is_prime (rsp_input_is_prime)
   );

endmodule
